// ----- rtl/rcv_pkg.sv -----
`timescale 1ns / 1ps

package rcv_pkg;

	localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
	localparam logic [2:0]  CHECKSUM_BYTES = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       record_end;
	} rcv_item_t;

	typedef struct packed {
		logic [31:0] crc_value;
		logic        checksum_match;
		logic        record_short;
	} rcv_result_t;

	// Reflected CRC-32, one byte, LSB first.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {24'd0, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/rcv_channels.sv -----
`timescale 1ns / 1ps

interface rcv_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       record_end;

	modport source (output valid, output data_byte, output record_end, input ready);
	modport sink   (input valid, input data_byte, input record_end, output ready);
endinterface

interface rcv_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] crc_value;
	logic        checksum_match;
	logic        record_short;

	modport source (output valid, output crc_value, output checksum_match,
		output record_short, input ready);
	modport sink   (input valid, input crc_value, input checksum_match,
		input record_short, output ready);
endinterface

// ----- rtl/rcv_in_stage.sv -----
`timescale 1ns / 1ps

module rcv_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rcv_pkg::rcv_item_t in_item,
	output logic              valid_s1,
	input  logic              take_s1,
	output rcv_pkg::rcv_item_t item_s1
);
	import rcv_pkg::*;

	logic v_s1;

	assign in_ready = !v_s1 || take_s1;
	assign valid_s1 = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ----- rtl/rcv_core.sv -----
`timescale 1ns / 1ps

module rcv_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	output logic                take_s1,
	input  rcv_pkg::rcv_item_t   item_s1,
	output logic                res_valid,
	input  logic                res_ready,
	output rcv_pkg::rcv_result_t res
);
	import rcv_pkg::*;

	logic [31:0] crc_q;
	logic [31:0] stored_q;
	logic [2:0]  hdr_pos_q;
	logic        res_valid_q;
	rcv_result_t res_q;

	logic [31:0] crc_nx;
	logic [31:0] stored_nx;
	logic [2:0]  hdr_pos_nx;
	logic        in_header;
	logic        out_free;
	logic        fire;
	rcv_result_t res_nx;

	assign in_header = hdr_pos_q < CHECKSUM_BYTES;
	assign out_free  = !res_valid_q || res_ready;
	// a non-final word never needs the result register
	assign take_s1   = !item_s1.record_end || out_free;
	assign fire      = valid_s1 && take_s1;

	always_comb begin
		crc_nx     = crc_q;
		stored_nx  = stored_q;
		hdr_pos_nx = hdr_pos_q;
		if (in_header) begin
			case (hdr_pos_q[1:0])
				2'd0: stored_nx[7:0]   = item_s1.data_byte;
				2'd1: stored_nx[15:8]  = item_s1.data_byte;
				2'd2: stored_nx[23:16] = item_s1.data_byte;
				2'd3: stored_nx[31:24] = item_s1.data_byte;
				default: stored_nx = stored_q;
			endcase
			hdr_pos_nx = hdr_pos_q + 3'd1;
		end else begin
			crc_nx = crc_byte(crc_q, item_s1.data_byte);
		end
		res_nx.crc_value      = ~crc_nx;
		res_nx.record_short   = hdr_pos_nx < CHECKSUM_BYTES;
		res_nx.checksum_match = !res_nx.record_short && (stored_nx == ~crc_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= CRC_INIT;
			stored_q    <= '0;
			hdr_pos_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire && item_s1.record_end) begin
				crc_q     <= CRC_INIT;
				stored_q  <= '0;
				hdr_pos_q <= '0;
			end else if (fire) begin
				crc_q     <= crc_nx;
				stored_q  <= stored_nx;
				hdr_pos_q <= hdr_pos_nx;
			end
			if (out_free) begin
				res_valid_q <= fire && item_s1.record_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fire && item_s1.record_end) begin
			res_q <= res_nx;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- rtl/record_crc32_verifier.sv -----
`timescale 1ns / 1ps
// Path: a final word passes the input register, then the result register,
// where its result is held until taken.
// Throughput: one word per cycle; the CRC byte update is an 8-step unrolled
// shift/xor between the input register and the result register. A final word
// waits in the input register only while a result is held; other words pass.
// Reset (arst_n low, asynchronous): CRC all ones, stored checksum and header
// count zero, no result pending. A record's end resets the first three.
module record_crc32_verifier (
	input logic         clk,
	input logic         arst_n,
	rcv_byte_if.sink    rec_bytes,
	rcv_result_if.source result
);
	import rcv_pkg::*;

	rcv_item_t   in_item;
	rcv_item_t   item_s1;
	rcv_result_t res;
	logic        valid_s1;
	logic        take_s1;
	logic        in_ready;

	assign in_item.data_byte  = rec_bytes.data_byte;
	assign in_item.record_end = rec_bytes.record_end;
	assign rec_bytes.ready    = in_ready;

	rcv_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rec_bytes.valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.take_s1  (take_s1),
		.item_s1  (item_s1)
	);

	rcv_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.take_s1   (take_s1),
		.item_s1   (item_s1),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.res       (res)
	);

	assign result.crc_value      = res.crc_value;
	assign result.checksum_match = res.checksum_match;
	assign result.record_short   = res.record_short;

endmodule

// ----- rtl/rcv_checker.sv -----
`timescale 1ns / 1ps

module rcv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_end,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] crc_value,
	input logic        checksum_match,
	input logic        record_short
);

	// a result word holds while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(crc_value)
			&& $stable(checksum_match) && $stable(record_short))
		else $error("result word changed while stalled");

	// a short record never matches and carries an empty CRC
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && record_short |-> !checksum_match && crc_value == 32'd0)
		else $error("short record with match or nonzero CRC");

	// a result only follows an accepted final word, or a result that was taken
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(in_valid && in_ready && in_end, 2)
			|| $past(res_valid && res_ready))
		else $error("result without a final word");

	// with the output free, the input side is never blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid && !$past(in_valid) |-> in_ready)
		else $error("input stalled with empty pipeline");

endmodule

bind record_crc32_verifier rcv_checker u_rcv_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (rec_bytes.valid),
	.in_ready       (rec_bytes.ready),
	.in_end         (rec_bytes.record_end),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.crc_value      (result.crc_value),
	.checksum_match (result.checksum_match),
	.record_short   (result.record_short)
);
